/* rtl/core/ccl_pkg.sv */
// Shared types and constants for the chat command line classifier.
// Holds the verb table, result codes and the result record; no dependencies.
`timescale 1ns / 1ps

package ccl_pkg;

    // Default width of the running line counters
    localparam int LEN_BITS_DEFAULT = 12;

    // Width of every length and offset field of a result
    localparam int FIELD_BITS = 12;

    // Configuration register widths, reset values and indexes
    localparam int MAX_LINE_BITS = 12;
    localparam int MAX_NICK_BITS = 7;
    localparam int CFG_INDEX_BITS = 4;
    localparam int CFG_DATA_BITS = 12;
    localparam logic [MAX_LINE_BITS-1:0] MAX_LINE_RESET = 12'd1024;
    localparam logic [MAX_NICK_BITS-1:0] MAX_NICK_RESET = 7'd32;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_LINE_BYTES = 4'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_NICKNAME_LEN = 4'd1;

    // Stream characters
    localparam logic [7:0] CHAR_LF = 8'h0a;
    localparam logic [7:0] CHAR_CR = 8'h0d;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_UNDERSCORE = 8'h5f;

    // Verb table: bit k of the candidate mask tracks verb k
    localparam int NUM_VERBS = 5;
    localparam int VERB_TEXT_LEN = 8;
    localparam int VERB_LOGIN = 0;
    localparam int VERB_MSG = 1;
    localparam int VERB_PRIVATE = 2;
    localparam int VERB_LIST = 3;
    localparam int VERB_QUIT = 4;
    localparam int VERB_POS_BITS = 4;

    localparam logic [7:0] VERB_TEXT [NUM_VERBS][VERB_TEXT_LEN] = '{
        '{"L", "O", "G", "I", "N", 8'h00, 8'h00, 8'h00},
        '{"M", "S", "G", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"P", "R", "I", "V", "A", "T", "E", 8'h00},
        '{"L", "I", "S", "T", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"Q", "U", "I", "T", 8'h00, 8'h00, 8'h00, 8'h00}
    };
    localparam logic [VERB_POS_BITS-1:0] VERB_LEN [NUM_VERBS] = '{
        4'd5, 4'd3, 4'd7, 4'd4, 4'd4
    };

    // Offsets of the name and content fields after each verb
    localparam logic [FIELD_BITS-1:0] LOGIN_NAME_OFFSET = 12'd6;
    localparam logic [FIELD_BITS-1:0] MSG_CONTENT_OFFSET = 12'd4;
    localparam logic [FIELD_BITS-1:0] PRIVATE_NAME_OFFSET = 12'd8;
    localparam logic [FIELD_BITS-1:0] PRIVATE_CONTENT_BASE = 12'd9;

    typedef enum logic [2:0] {
        KIND_INVALID = 3'd0,
        KIND_LOGIN   = 3'd1,
        KIND_MESSAGE = 3'd2,
        KIND_PRIVATE = 3'd3,
        KIND_LIST    = 3'd4,
        KIND_QUIT    = 3'd5
    } ccl_kind_t;

    typedef enum logic [2:0] {
        ERR_NONE           = 3'd0,
        ERR_TOO_LONG       = 3'd1,
        ERR_NICK_REQUIRED  = 3'd2,
        ERR_INVALID_CMD    = 3'd3,
        ERR_INVALID_NICK   = 3'd4
    } ccl_error_t;

    // Verb and name status of the line in progress
    typedef struct packed {
        logic [NUM_VERBS-1:0]     verb_candidates;
        logic [VERB_POS_BITS-1:0] verb_position;
        logic                     space_seen;
        logic                     rest_space_seen;
        logic                     name_chars_ok;
    } ccl_flags_t;

    // One classified line
    typedef struct packed {
        logic [FIELD_BITS-1:0] content_length;
        logic [FIELD_BITS-1:0] content_offset;
        logic [FIELD_BITS-1:0] name_length;
        logic [FIELD_BITS-1:0] name_offset;
        logic [FIELD_BITS-1:0] line_length;
        ccl_error_t            error_code;
        ccl_kind_t             command_kind;
    } ccl_result_t;

endpackage

/* rtl/core/ccl_line_tracker.sv */
// Running line state of the classifier: counters and flags updated per byte.
// Depends on ccl_pkg for the verb table and the flag record.
`timescale 1ns / 1ps

module ccl_line_tracker #(
    parameter int LEN_BITS = ccl_pkg::LEN_BITS_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                byte_accept,
    input  logic [7:0]          data_byte,
    output logic [LEN_BITS-1:0] raw_count,
    output logic [LEN_BITS-1:0] rest_count,
    output logic [LEN_BITS-1:0] rest_space_position,
    output ccl_pkg::ccl_flags_t flags
);
    import ccl_pkg::*;

    typedef struct packed {
        logic [NUM_VERBS-1:0]     cand;
        logic [VERB_POS_BITS-1:0] pos;
        logic                     space;
        logic [LEN_BITS-1:0]      rest;
        logic                     rest_space;
        logic [LEN_BITS-1:0]      rest_space_pos;
        logic                     name_ok;
    } line_state_t;

    localparam line_state_t LINE_CLEAR = '{
        cand: '1, pos: '0, space: 1'b0, rest: '0,
        rest_space: 1'b0, rest_space_pos: '0, name_ok: 1'b1
    };

    line_state_t        line_reg, line_next;
    logic [LEN_BITS-1:0] raw_reg, raw_next;
    logic               cr_held_reg, cr_held_next;
    line_state_t        after_cr;

    function automatic logic is_name_char(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
               (c >= "0" && c <= "9") || c == CHAR_UNDERSCORE;
    endfunction

    // Fold one byte of the stripped line into the line state
    function automatic line_state_t take_byte(input line_state_t s, input logic [7:0] c);
        line_state_t r;
        r = s;
        if (!s.space) begin
            if (c == CHAR_SPACE) begin
                r.space = 1'b1;
            end else begin
                for (int k = 0; k < NUM_VERBS; k++) begin
                    if (s.pos >= VERB_LEN[k] || VERB_TEXT[k][s.pos[2:0]] != c) begin
                        r.cand[k] = 1'b0;
                    end
                end
                if (s.pos != '1) begin
                    r.pos = s.pos + 1'b1;
                end
            end
        end else begin
            if (!s.rest_space) begin
                if (c == CHAR_SPACE) begin
                    r.rest_space = 1'b1;
                    r.rest_space_pos = s.rest;
                end else if (!is_name_char(c)) begin
                    r.name_ok = 1'b0;
                end
            end
            if (s.rest != '1) begin
                r.rest = s.rest + 1'b1;
            end
        end
        return r;
    endfunction

    // Next state: LF clears the line, else held CR then any non-CR byte go in
    always_comb begin
        line_next    = line_reg;
        raw_next     = raw_reg;
        cr_held_next = cr_held_reg;
        after_cr     = cr_held_reg ? take_byte(line_reg, CHAR_CR) : line_reg;
        if (byte_accept) begin
            if (data_byte == CHAR_LF) begin
                line_next    = LINE_CLEAR;
                raw_next     = '0;
                cr_held_next = 1'b0;
            end else begin
                raw_next = (raw_reg == '1) ? raw_reg : raw_reg + 1'b1;
                if (data_byte == CHAR_CR) begin
                    line_next    = after_cr;
                    cr_held_next = 1'b1;
                end else begin
                    line_next    = take_byte(after_cr, data_byte);
                    cr_held_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_reg    <= LINE_CLEAR;
            raw_reg     <= '0;
            cr_held_reg <= 1'b0;
        end else begin
            line_reg    <= line_next;
            raw_reg     <= raw_next;
            cr_held_reg <= cr_held_next;
        end
    end

    assign raw_count           = raw_reg;
    assign rest_count          = line_reg.rest;
    assign rest_space_position = line_reg.rest_space_pos;
    assign flags = '{
        verb_candidates: line_reg.cand,
        verb_position:   line_reg.pos,
        space_seen:      line_reg.space,
        rest_space_seen: line_reg.rest_space,
        name_chars_ok:   line_reg.name_ok
    };

endmodule

/* rtl/core/ccl_classifier.sv */
// Classifies the finished line from the running state into a result record.
// Depends on ccl_pkg for codes, verb lengths and the result record.
`timescale 1ns / 1ps

module ccl_classifier #(
    parameter int LEN_BITS = ccl_pkg::LEN_BITS_DEFAULT
) (
    input  logic [LEN_BITS-1:0]                raw_count,
    input  logic [LEN_BITS-1:0]                rest_count,
    input  logic [LEN_BITS-1:0]                rest_space_position,
    input  ccl_pkg::ccl_flags_t                flags,
    input  logic [ccl_pkg::MAX_LINE_BITS-1:0]  max_line_bytes,
    input  logic [ccl_pkg::MAX_NICK_BITS-1:0]  max_nickname_len,
    output ccl_pkg::ccl_result_t               result
);
    import ccl_pkg::*;

    // Compare width wide enough for counters and register values
    localparam int CW = (LEN_BITS > FIELD_BITS) ? LEN_BITS : FIELD_BITS;
    localparam int W1 = LEN_BITS + 1;

    logic [NUM_VERBS-1:0] verb_hit;
    logic                 too_long;
    logic                 login_name_ok;
    logic                 target_name_ok;
    logic                 private_short;

    // Mark verbs that matched all the way to their end
    always_comb begin
        for (int k = 0; k < NUM_VERBS; k++) begin
            verb_hit[k] = flags.verb_candidates[k] && (flags.verb_position == VERB_LEN[k]);
        end
    end

    assign too_long = (CW'(raw_count) > CW'(max_line_bytes)) || (raw_count == '1);

    assign login_name_ok = (rest_count != '0) &&
                           (CW'(rest_count) <= CW'(max_nickname_len)) &&
                           flags.name_chars_ok;
    assign target_name_ok = (rest_space_position != '0) &&
                            (CW'(rest_space_position) <= CW'(max_nickname_len)) &&
                            flags.name_chars_ok;
    assign private_short = (rest_count == '0) || !flags.rest_space_seen ||
                           (W1'(rest_space_position) + W1'(1) >= W1'(rest_count));

    // Decide kind and error; unused fields stay zero
    always_comb begin
        result = '0;
        result.command_kind = KIND_INVALID;
        result.error_code   = ERR_NONE;
        result.line_length  = FIELD_BITS'(raw_count);
        if (too_long) begin
            result.error_code = ERR_TOO_LONG;
        end else if (verb_hit[VERB_QUIT] || verb_hit[VERB_LIST]) begin
            if (flags.space_seen) begin
                result.error_code = ERR_INVALID_CMD;
            end else begin
                result.command_kind = verb_hit[VERB_QUIT] ? KIND_QUIT : KIND_LIST;
            end
        end else if (verb_hit[VERB_PRIVATE]) begin
            if (private_short) begin
                result.error_code = ERR_INVALID_CMD;
            end else if (!target_name_ok) begin
                result.error_code = ERR_INVALID_NICK;
            end else begin
                result.command_kind   = KIND_PRIVATE;
                result.name_offset    = PRIVATE_NAME_OFFSET;
                result.name_length    = FIELD_BITS'(rest_space_position);
                result.content_offset = FIELD_BITS'(CW'(rest_space_position) +
                                                    CW'(PRIVATE_CONTENT_BASE));
                result.content_length = FIELD_BITS'(rest_count - rest_space_position - 1'b1);
            end
        end else if (verb_hit[VERB_MSG]) begin
            if (rest_count == '0) begin
                result.error_code = ERR_INVALID_CMD;
            end else begin
                result.command_kind   = KIND_MESSAGE;
                result.content_offset = MSG_CONTENT_OFFSET;
                result.content_length = FIELD_BITS'(rest_count);
            end
        end else if (verb_hit[VERB_LOGIN]) begin
            if (rest_count == '0) begin
                result.error_code = ERR_NICK_REQUIRED;
            end else if (flags.rest_space_seen) begin
                result.error_code = ERR_INVALID_CMD;
            end else if (!login_name_ok) begin
                result.error_code = ERR_INVALID_NICK;
            end else begin
                result.command_kind = KIND_LOGIN;
                result.name_offset  = LOGIN_NAME_OFFSET;
                result.name_length  = FIELD_BITS'(rest_count);
            end
        end else begin
            result.error_code = ERR_INVALID_CMD;
        end
    end

endmodule

/* rtl/core/chat_command_line_classifier.sv */
// Top level of the chat command line classifier: handshakes, registers, result.
// Depends on ccl_pkg, ccl_line_tracker and ccl_classifier.
`timescale 1ns / 1ps

// Takes one byte per cycle on the s_ stream and emits one classified result on the m_
// stream for each newline byte, in the cycle after that byte is accepted. The per-byte
// counter and flag update in the line tracker keeps up with the input, so a new byte is
// accepted in every cycle; input stalls only while a result sits in the output
// register and m_tready is low. Lines are never stored; LEN_BITS sets the width of the
// running counters, which saturate at all ones. Configuration writes on cfg_ are taken
// in any cycle and should be made only while no line is in progress.
module chat_command_line_classifier #(
    parameter int LEN_BITS = ccl_pkg::LEN_BITS_DEFAULT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,   // [7:0] data_byte
    // Result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [2:0] command_kind, [5:3] error_code, [17:6] line_length, [29:18] name_offset,
    // [41:30] name_length, [53:42] content_offset, [65:54] content_length, [71:66] zero
    output logic [71:0]                        m_tdata,
    // Configuration writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ccl_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [ccl_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import ccl_pkg::*;

    logic                      byte_accept;
    logic                      line_end;
    logic [LEN_BITS-1:0]       raw_count;
    logic [LEN_BITS-1:0]       rest_count;
    logic [LEN_BITS-1:0]       rest_space_position;
    ccl_flags_t                flags;
    ccl_result_t               line_result;

    logic [MAX_LINE_BITS-1:0]  max_line_reg;
    logic [MAX_NICK_BITS-1:0]  max_nick_reg;
    logic                      out_valid_reg, out_valid_next;
    ccl_result_t               out_data_reg;

    assign s_tready    = !out_valid_reg || m_tready;
    assign byte_accept = s_tvalid && s_tready;
    assign line_end    = byte_accept && (s_tdata == CHAR_LF);
    assign cfg_ready   = 1'b1;

    ccl_line_tracker #(
        .LEN_BITS(LEN_BITS)
    ) u_tracker (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .byte_accept         (byte_accept),
        .data_byte           (s_tdata),
        .raw_count           (raw_count),
        .rest_count          (rest_count),
        .rest_space_position (rest_space_position),
        .flags               (flags)
    );

    ccl_classifier #(
        .LEN_BITS(LEN_BITS)
    ) u_classifier (
        .raw_count           (raw_count),
        .rest_count          (rest_count),
        .rest_space_position (rest_space_position),
        .flags               (flags),
        .max_line_bytes      (max_line_reg),
        .max_nickname_len    (max_nick_reg),
        .result              (line_result)
    );

    // Hold configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_line_reg <= MAX_LINE_RESET;
            max_nick_reg <= MAX_NICK_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_MAX_LINE_BYTES:   max_line_reg <= cfg_data[MAX_LINE_BITS-1:0];
                REG_MAX_NICKNAME_LEN: max_nick_reg <= cfg_data[MAX_NICK_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Load a result on newline, drop it once taken
    always_comb begin
        out_valid_next = out_valid_reg;
        if (line_end) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (line_end) begin
            out_data_reg <= line_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_data_reg};

endmodule

/* rtl/core/ccl_checker.sv */
// Port-level checks for the chat command line classifier, bound to the top level.
// Depends on the top level's port list only.
`timescale 1ns / 1ps

module ccl_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata
);

    // Input must be open whenever no result is pending
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result register");

    // A new result follows only an accepted newline
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tdata == 8'h0a))
        else $error("result without newline");

    // A non-newline item into a free result register makes no result
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tdata != 8'h0a && !(m_tvalid && !m_tready)
        |=> !m_tvalid)
        else $error("result from non-newline item");

    // Kind is invalid exactly when an error is reported
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[2:0] == 3'd0) != (m_tdata[5:3] == 3'd0)))
        else $error("kind and error code disagree");

    // A stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

endmodule

bind chat_command_line_classifier ccl_checker u_ccl_checker (.*);

/* sim/tb_chat_command_line_classifier.sv */
`timescale 1ns / 1ps
// Self-checking bench for chat_command_line_classifier: streams text lines through the
// byte input, predicts every line result and compares each output item field by field.
// Depends on ccl_pkg and the classifier RTL only.

module tb_chat_command_line_classifier;
    import ccl_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int SETTLE_CYCLES = 4;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int MAX_REPORTS = 40;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE = 4'd15;
    localparam logic [FIELD_BITS-1:0] COUNT_TOP = '1;
    localparam logic [VERB_POS_BITS-1:0] POS_TOP = '1;

    // Line tracker mirror: running counters per line, one expected result per newline
    class command_line_predictor;
        logic [MAX_LINE_BITS-1:0] line_limit;
        logic [MAX_NICK_BITS-1:0] nick_limit;
        logic [FIELD_BITS-1:0]    raw_count;
        logic                     cr_held;
        logic [NUM_VERBS-1:0]     verb_cands;
        logic [VERB_POS_BITS-1:0] verb_pos;
        logic                     space_seen;
        logic [FIELD_BITS-1:0]    rest_count;
        logic                     rest_space_seen;
        logic [FIELD_BITS-1:0]    rest_space_pos;
        logic                     name_chars_ok;
        ccl_result_t              pending_results[$];
        int                       errors;

        function new();
            line_limit = MAX_LINE_RESET;
            nick_limit = MAX_NICK_RESET;
            errors = 0;
            clear_line();
        endfunction

        function void clear_line();
            raw_count = '0;
            cr_held = 1'b0;
            verb_cands = '1;
            verb_pos = '0;
            space_seen = 1'b0;
            rest_count = '0;
            rest_space_seen = 1'b0;
            rest_space_pos = '0;
            name_chars_ok = 1'b1;
        endfunction

        function void write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] value);
            if (idx == REG_MAX_LINE_BYTES) begin
                line_limit = value[MAX_LINE_BITS-1:0];
            end else if (idx == REG_MAX_NICKNAME_LEN) begin
                nick_limit = value[MAX_NICK_BITS-1:0];
            end
        endfunction

        function bit name_valid(int len);
            return len >= 1 && len <= int'(nick_limit) && name_chars_ok;
        endfunction

        // Advance verb matching before the first space, name and content counts after it
        function void take_line_byte(logic [7:0] c);
            if (!space_seen) begin
                if (c == CHAR_SPACE) begin
                    space_seen = 1'b1;
                    return;
                end
                for (int k = 0; k < NUM_VERBS; k++) begin
                    if (verb_pos >= VERB_LEN[k] || VERB_TEXT[k][verb_pos] != c)
                        verb_cands[k] = 1'b0;
                end
                if (verb_pos != POS_TOP) verb_pos++;
                return;
            end
            if (!rest_space_seen) begin
                if (c == CHAR_SPACE) begin
                    rest_space_seen = 1'b1;
                    rest_space_pos = rest_count;
                end else if (!((c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
                               (c >= "0" && c <= "9") || c == CHAR_UNDERSCORE)) begin
                    name_chars_ok = 1'b0;
                end
            end
            if (rest_count != COUNT_TOP) rest_count++;
        endfunction

        // Classify the finished line and queue its result
        function void close_line();
            ccl_result_t r;
            int verb;
            int rc;
            int rsp;
            r.command_kind = KIND_INVALID;
            r.error_code = ERR_NONE;
            r.line_length = raw_count;
            r.name_offset = '0;
            r.name_length = '0;
            r.content_offset = '0;
            r.content_length = '0;
            verb = -1;
            rc = rest_count;
            rsp = rest_space_pos;
            for (int k = 0; k < NUM_VERBS; k++) begin
                if (verb_cands[k] && verb_pos == VERB_LEN[k]) verb = k;
            end
            if (raw_count > line_limit || raw_count == COUNT_TOP) begin
                r.error_code = ERR_TOO_LONG;
            end else if (verb == VERB_LOGIN) begin
                if (rc == 0) begin
                    r.error_code = ERR_NICK_REQUIRED;
                end else if (rest_space_seen) begin
                    r.error_code = ERR_INVALID_CMD;
                end else if (!name_valid(rc)) begin
                    r.error_code = ERR_INVALID_NICK;
                end else begin
                    r.command_kind = KIND_LOGIN;
                    r.name_offset = LOGIN_NAME_OFFSET;
                    r.name_length = rest_count;
                end
            end else if (verb == VERB_MSG) begin
                if (rc == 0) begin
                    r.error_code = ERR_INVALID_CMD;
                end else begin
                    r.command_kind = KIND_MESSAGE;
                    r.content_offset = MSG_CONTENT_OFFSET;
                    r.content_length = rest_count;
                end
            end else if (verb == VERB_PRIVATE) begin
                if (rc == 0 || !rest_space_seen || rsp + 1 >= rc) begin
                    r.error_code = ERR_INVALID_CMD;
                end else if (!name_valid(rsp)) begin
                    r.error_code = ERR_INVALID_NICK;
                end else begin
                    r.command_kind = KIND_PRIVATE;
                    r.name_offset = PRIVATE_NAME_OFFSET;
                    r.name_length = rest_space_pos;
                    r.content_offset = PRIVATE_CONTENT_BASE + rest_space_pos;
                    r.content_length = rest_count - rest_space_pos - 1'b1;
                end
            end else if (verb == VERB_LIST || verb == VERB_QUIT) begin
                if (space_seen) r.error_code = ERR_INVALID_CMD;
                else r.command_kind = (verb == VERB_LIST) ? KIND_LIST : KIND_QUIT;
            end else begin
                r.error_code = ERR_INVALID_CMD;
            end
            pending_results = {pending_results, r};
        endfunction

        // Note one accepted input item; a CR waits one byte to see if the newline follows
        function void note_byte(logic [7:0] c);
            if (c == CHAR_LF) begin
                close_line();
                clear_line();
                return;
            end
            if (raw_count != COUNT_TOP) raw_count++;
            if (cr_held) begin
                take_line_byte(CHAR_CR);
                cr_held = 1'b0;
            end
            if (c == CHAR_CR) cr_held = 1'b1;
            else take_line_byte(c);
        endfunction

        function void check_field(string name, int want, int got);
            if (want != got) begin
                if (errors < MAX_REPORTS)
                    $display("%0t: %s mismatch, expected %0d, actual %0d",
                             $time, name, want, got);
                errors++;
            end
        endfunction

        // Compare one output item with the oldest expected line result
        function void check_result(logic [71:0] data);
            ccl_result_t want;
            ccl_result_t got;
            got = ccl_result_t'(data[65:0]);
            if (pending_results.size() == 0) begin
                if (errors < MAX_REPORTS)
                    $display("%0t: result with none expected, expected nothing, actual %h",
                             $time, data);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            check_field("command_kind", int'(want.command_kind), int'(got.command_kind));
            check_field("error_code", int'(want.error_code), int'(got.error_code));
            check_field("line_length", want.line_length, got.line_length);
            check_field("name_offset", want.name_offset, got.name_offset);
            check_field("name_length", want.name_length, got.name_length);
            check_field("content_offset", want.content_offset, got.content_offset);
            check_field("content_length", want.content_length, got.content_length);
            check_field("padding", 0, data[71:66]);
        endfunction
    endclass

    logic                      aclk;
    logic                      aresetn;
    logic                      s_tvalid;
    logic                      s_tready;
    logic [7:0]                s_tdata;    // [7:0] data_byte
    logic                      m_tvalid;
    logic                      m_tready;
    // [2:0] command_kind, [5:3] error_code, [17:6] line_length, [29:18] name_offset,
    // [41:30] name_length, [53:42] content_offset, [65:54] content_length
    logic [71:0]               m_tdata;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    command_line_predictor predictor = new();
    int cycle_count = 0;
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int hold_left = 0;
    int bytes_sent = 0;
    logic [MAX_NICK_BITS-1:0] cur_nick = MAX_NICK_RESET;

    chat_command_line_classifier uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // Watch all three channels; results first, since none can come from this edge's input
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) predictor.check_result(m_tdata);
            if (s_tvalid && s_tready) predictor.note_byte(s_tdata);
            if (cfg_valid && cfg_ready) predictor.write_reg(cfg_index, cfg_data);
        end
    end

    // Result side: random stalls, or a long hold-off when requested
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    initial begin
        wait (cycle_count >= LIMIT_CYCLES);
        $display("tb_chat_command_line_classifier failed");
        $finish;
    end

    function automatic logic [7:0] name_char();
        int r;
        r = $urandom_range(62);
        if (r < 26) return 8'("A" + r);
        if (r < 52) return 8'("a" + r - 26);
        if (r < 62) return 8'("0" + r - 52);
        return CHAR_UNDERSCORE;
    endfunction

    function automatic logic [7:0] text_char();
        logic [7:0] b;
        b = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(32, 126));
        if (b == CHAR_LF) b = CHAR_UNDERSCORE;
        return b;
    endfunction

    // Offer one item, idling at random first; return once it is taken
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        bytes_sent++;
    endtask

    task automatic send_text(input string chars);
        for (int i = 0; i < chars.len(); i++) send_byte(chars[i]);
    endtask

    task automatic send_repeat(input logic [7:0] b, input int count);
        repeat (count) send_byte(b);
    endtask

    // Leaves cfg_valid high so that writes can follow back to back
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic set_limits(input logic [CFG_DATA_BITS-1:0] line_value,
                              input logic [CFG_DATA_BITS-1:0] nick_value);
        write_reg(REG_MAX_LINE_BYTES, line_value);
        write_reg(REG_MAX_NICKNAME_LEN, nick_value);
        cur_nick = nick_value[MAX_NICK_BITS-1:0];
    endtask

    // Stop sending and wait until every expected line result has come out
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (predictor.pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Mostly well-formed commands with random content, the rest noise and broken verbs
    task automatic send_random_line();
        logic [7:0] line_q[$];
        int pick;
        int k;
        int name_cap;
        int name_len;
        int r;
        pick = $urandom_range(99);
        name_cap = (cur_nick > 12) ? 12 : ((cur_nick == 0) ? 1 : cur_nick);
        name_len = ($urandom_range(9) < 8) ? $urandom_range(1, name_cap)
                                           : $urandom_range(0, cur_nick + 2);
        k = $urandom_range(NUM_VERBS - 1);
        if (pick < 85) begin
            for (int i = 0; i < VERB_LEN[k]; i++) line_q = {line_q, VERB_TEXT[k][i]};
            if (pick >= 70) begin
                // broken verb: drop its last letter or lowercase one
                if ($urandom_range(1) == 0) line_q.pop_back();
                else begin
                    r = $urandom_range(line_q.size() - 1);
                    line_q[r] = line_q[r] | 8'h20;
                end
            end
            case (k)
                VERB_LOGIN: begin
                    line_q = {line_q, CHAR_SPACE};
                    repeat (name_len) line_q = {line_q, name_char()};
                end
                VERB_MSG: begin
                    line_q = {line_q, CHAR_SPACE};
                    repeat ($urandom_range(20)) line_q = {line_q, text_char()};
                end
                VERB_PRIVATE: begin
                    line_q = {line_q, CHAR_SPACE};
                    repeat (name_len) line_q = {line_q, name_char()};
                    line_q = {line_q, CHAR_SPACE};
                    repeat ($urandom_range(20)) line_q = {line_q, text_char()};
                end
                default: ;
            endcase
            if ($urandom_range(9) == 0) begin
                line_q = {line_q, CHAR_SPACE};
                repeat ($urandom_range(1, 4)) line_q = {line_q, text_char()};
            end
            if ($urandom_range(9) == 0) begin
                r = $urandom_range(line_q.size() - 1);
                line_q[r] = text_char();
            end
        end else begin
            // raw noise, newlines included
            repeat ($urandom_range(15)) line_q = {line_q, 8'($urandom_range(255))};
        end
        r = $urandom_range(9);
        if (r < 3) line_q = {line_q, CHAR_CR};
        else if (r == 3) begin
            line_q = {line_q, CHAR_CR};
            line_q = {line_q, CHAR_CR};
        end
        line_q = {line_q, CHAR_LF};
        foreach (line_q[i]) send_byte(line_q[i]);
    endtask

    task automatic run_random(input int target);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < target) send_random_line();
    endtask

    initial begin
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed lines at the reset limits: every verb, every error but too-long, CR cases
        send_text("LOGIN bob"); send_byte(CHAR_LF);
        send_text("LOGIN"); send_byte(CHAR_LF);
        send_text("LOGIN "); send_byte(CHAR_LF);
        send_text("LOGIN a b"); send_byte(CHAR_LF);
        send_text("LOGIN b@d"); send_byte(CHAR_LF);
        send_text("LOGIN "); send_repeat("a", 33); send_byte(CHAR_LF);
        send_text("LOGIN "); send_repeat("Z", 32); send_byte(CHAR_LF);
        send_text("MSG hello there"); send_byte(CHAR_CR); send_byte(CHAR_LF);
        send_text("MSG"); send_byte(CHAR_LF);
        send_text("MSG "); send_byte(CHAR_LF);
        send_text("MSG "); send_byte(8'h00); send_byte(8'hff); send_byte(CHAR_LF);
        send_text("MSG a"); send_byte(CHAR_CR); send_text("b"); send_byte(CHAR_LF);
        send_text("PRIVATE bob hi there"); send_byte(CHAR_LF);
        send_text("PRIVATE bob"); send_byte(CHAR_LF);
        send_text("PRIVATE bob "); send_byte(CHAR_LF);
        send_text("PRIVATE  hi"); send_byte(CHAR_LF);
        send_text("PRIVATE b-b hi"); send_byte(CHAR_LF);
        send_text("LIST"); send_byte(CHAR_LF);
        send_text("LIST x"); send_byte(CHAR_LF);
        send_text("QUIT"); send_byte(CHAR_CR); send_byte(CHAR_LF);
        send_text("QUIT"); send_byte(CHAR_CR); send_byte(CHAR_CR); send_byte(CHAR_LF);
        send_byte(CHAR_LF);
        send_byte(CHAR_CR); send_byte(CHAR_LF);
        send_text("HELLO"); send_byte(CHAR_LF);
        send_text("login bob"); send_byte(CHAR_LF);
        send_text("LOGINX bob"); send_byte(CHAR_LF);
        drain();

        // Wide limits, no idling; hold the result side so the input backs up
        set_limits(12'd4094, 12'd64);
        cfg_valid <= 1'b0;
        @(negedge aclk) hold_left = LONG_HOLD_CYCLES;
        @(posedge aclk);
        run_random(15);
        drain();
        run_random(15);
        drain();

        // Tight limits with an idle sender
        set_limits(12'd20, 12'd1);
        cfg_valid <= 1'b0;
        tx_idle_pct = 70;
        run_random(20);
        drain();

        // Nickname write with bits above the register width, stalling receiver
        set_limits(12'd60, 12'h0c8);
        cfg_valid <= 1'b0;
        tx_idle_pct = 0;
        rx_stall_pct = 70;
        run_random(20);
        drain();

        // All-ones registers, a write to an unused index, both sides idling
        set_limits(12'hfff, 12'hfff);
        write_reg(REG_SPARE, 12'h5a5);
        cfg_valid <= 1'b0;
        tx_idle_pct = 24;
        rx_stall_pct = 24;
        run_random(20);
        drain();

        // Zero limits: every non-empty line too long, every name invalid
        set_limits(12'd0, 12'd0);
        cfg_valid <= 1'b0;
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        run_random(10);
        send_text("LOGIN"); send_byte(CHAR_LF);
        send_byte(CHAR_LF);
        drain();

        // Back to the reset limits
        set_limits(12'd1024, 12'd32);
        cfg_valid <= 1'b0;
        tx_idle_pct = 24;
        run_random(10);
        drain();

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        if (predictor.errors == 0 && predictor.pending_results.size() == 0) begin
            $display("tb_chat_command_line_classifier passed");
        end else begin
            $display("tb_chat_command_line_classifier failed");
        end
        $finish;
    end

endmodule
